@@ rtl/cxyz_pkg.sv @@
// shared types, constants and helpers of the camera rgb to xyz converter
`default_nettype none

package cxyz_pkg;

  // table geometry and number formats
  localparam int LEVELS         = 256;
  localparam int LEVEL_BITS     = 8;
  localparam int LUMA_BITS      = 20;
  localparam int COEF_BITS      = 20;
  localparam int COEF_FRAC_BITS = 12;
  localparam int NUM_CFG        = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int Y_BITS         = 22;
  localparam int XZ_BITS        = 32;

  // product of a signed coefficient and a zero-extended luminance
  localparam int PROD_BITS = COEF_BITS + LUMA_BITS + 1;
  // three products plus rounding half, with headroom
  localparam int SUM_BITS  = PROD_BITS + 2;

  localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
    SUM_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } chan_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_X_BLUE  = 3'd0,
    REG_X_GREEN = 3'd1,
    REG_X_RED   = 3'd2,
    REG_Z_BLUE  = 3'd3,
    REG_Z_GREEN = 3'd4,
    REG_Z_RED   = 3'd5
  } cfg_reg_e;

  localparam logic signed [COEF_BITS-1:0] COEF_RESET [NUM_CFG] = '{
    20'sd2048, 20'sd2458, 20'sd6827, 20'sd14336, 20'sd1638, 20'sd2731
  };

  // per-stage advance strobes of the result pipeline
  typedef struct packed {
    logic en_prod;
    logic en_sum;
    logic en_out;
  } stage_en_t;

  typedef struct packed {
    logic signed [XZ_BITS-1:0] value;
    logic                      clip;
  } sat_t;

  // floor shift to four fraction bits, then clip to the signed 32-bit range
  function automatic sat_t round_sat(input logic signed [SUM_BITS-1:0] sum);
    logic signed [SUM_BITS-1:0]     shifted;
    logic [SUM_BITS-XZ_BITS:0]      hi;
    sat_t                           res;
    shifted = sum >>> COEF_FRAC_BITS;
    hi      = shifted[SUM_BITS-1:XZ_BITS-1];
    if ((&hi) || !(|hi)) begin
      res.value = shifted[XZ_BITS-1:0];
      res.clip  = 1'b0;
    end else if (shifted[SUM_BITS-1]) begin
      res.value = {1'b1, {(XZ_BITS-1){1'b0}}};
      res.clip  = 1'b1;
    end else begin
      res.value = {1'b0, {(XZ_BITS-1){1'b1}}};
      res.clip  = 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cxyz_if.sv @@
// handshake channel interfaces: pixel/load input, result output, register write
`default_nettype none

interface cxyz_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [1:0]                          table_channel;
  logic [7:0]                          table_level;
  logic [cxyz_pkg::LUMA_BITS-1:0]      table_value;
  logic [7:0]                          blue;
  logic [7:0]                          green;
  logic [7:0]                          red;

  modport source (
    output valid, operation, table_channel, table_level, table_value,
           blue, green, red,
    input  ready
  );
  modport sink (
    input  valid, operation, table_channel, table_level, table_value,
           blue, green, red,
    output ready
  );
endinterface

interface cxyz_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cxyz_pkg::XZ_BITS-1:0] x_out;
  logic [cxyz_pkg::Y_BITS-1:0]         y_out;
  logic signed [cxyz_pkg::XZ_BITS-1:0] z_out;
  logic                                saturated;

  modport source (
    output valid, x_out, y_out, z_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, x_out, y_out, z_out, saturated,
    output ready
  );
endinterface

interface cxyz_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cxyz_pkg::CFG_IDX_BITS-1:0]   index;
  logic [cxyz_pkg::COEF_BITS-1:0]      data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/cxyz_lut.sv @@
// one channel luminance table: single write port, registered read port
`default_nettype none

module cxyz_lut (
  input  wire logic                                clk_i,
  input  wire logic                                wr_en_i,
  input  wire logic [cxyz_pkg::LEVEL_BITS-1:0]     wr_addr_i,
  input  wire logic [cxyz_pkg::LUMA_BITS-1:0]      wr_data_i,
  input  wire logic                                rd_en_i,
  input  wire logic [cxyz_pkg::LEVEL_BITS-1:0]     rd_addr_i,
  output      logic [cxyz_pkg::LUMA_BITS-1:0]      rd_data_o
);

  logic [cxyz_pkg::LUMA_BITS-1:0] mem_q [cxyz_pkg::LEVELS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/cxyz_mac.sv @@
// weighted sum of three luminances: multiply, sum and round, saturate
`default_nettype none

module cxyz_mac (
  input  wire logic                                   clk_i,
  input  wire cxyz_pkg::stage_en_t                    en_i,
  input  wire logic signed [cxyz_pkg::COEF_BITS-1:0]  coef_i [3],
  input  wire logic [cxyz_pkg::LUMA_BITS-1:0]         lum_i  [3],
  output      logic signed [cxyz_pkg::XZ_BITS-1:0]    value_o,
  output      logic                                   clip_o
);

  logic signed [cxyz_pkg::PROD_BITS-1:0] prod_d [3];
  logic signed [cxyz_pkg::PROD_BITS-1:0] prod_q [3];
  logic signed [cxyz_pkg::SUM_BITS-1:0]  sum_d;
  logic signed [cxyz_pkg::SUM_BITS-1:0]  sum_q;
  cxyz_pkg::sat_t                        sat_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = cxyz_pkg::PROD_BITS'(coef_i[i] * $signed({1'b0, lum_i[i]}));
    end
  end

  // sum carries the rounding half so the output stage is shift and clip only
  assign sum_d = cxyz_pkg::SUM_BITS'(prod_q[0]) + cxyz_pkg::SUM_BITS'(prod_q[1])
               + cxyz_pkg::SUM_BITS'(prod_q[2]) + cxyz_pkg::ROUND_HALF;

  assign sat_d = cxyz_pkg::round_sat(sum_q);

  always_ff @(posedge clk_i) begin
    if (en_i.en_prod) begin
      prod_q <= prod_d;
    end
    if (en_i.en_sum) begin
      sum_q <= sum_d;
    end
    if (en_i.en_out) begin
      value_o <= sat_d.value;
      clip_o  <= sat_d.clip;
    end
  end

endmodule

`default_nettype wire

@@ rtl/camera_rgb_to_xyz_converter.sv @@
// top level: camera pixel to cie xyz converter with loadable luminance tables
//
// channels
//   pix_i : input beats; operation load writes one luminance table entry
//           (table_channel, table_level, table_value), operation convert
//           looks up blue, green and red and yields one result beat
//   res_o : result beats x_out, y_out, z_out (q27.4 / q18.4) and saturated
//   cfg_i : register writes, index 0..5 selects a coefficient, always ready
// pipeline : an accepted convert beat passes the table read, products, sum
//           with rounding and saturate registers before its result beat
// throughput : one beat per cycle unless a result stalls; set by the single
//           read port of each channel table, which is read once per pixel
// load beats pass through as bubbles and give no result
// stall : every stage holds only while the stage after it is full and
//         blocked, so bubbles are squeezed out and input is taken while a
//         result waits in the output register
// reset : clears stage valid bits and loads the default coefficients; the
//         tables hold nothing defined until loaded, no clearing pass
`default_nettype none

module camera_rgb_to_xyz_converter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  cxyz_in_if.sink         pix_i,
  cxyz_out_if.source      res_o,
  cxyz_cfg_if.sink        cfg_i
);

  // coefficient registers
  logic signed [cxyz_pkg::COEF_BITS-1:0] coef_q [cxyz_pkg::NUM_CFG];

  // stage valid bits: lum, prod, sum, out
  logic v_lum_q, v_prod_q, v_sum_q, v_out_q;
  logic en_lum;
  cxyz_pkg::stage_en_t en;

  logic accept, is_convert, is_load;

  logic [cxyz_pkg::LUMA_BITS-1:0] lum [3];
  logic [2:0]                     wr_en;

  logic [cxyz_pkg::Y_BITS-1:0] y_prod_d;
  logic [cxyz_pkg::Y_BITS-1:0] y_prod_q, y_sum_q, y_out_q;

  logic signed [cxyz_pkg::COEF_BITS-1:0] coef_x [3];
  logic signed [cxyz_pkg::COEF_BITS-1:0] coef_z [3];
  logic clip_x, clip_z;

  // register writes are never refused
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= cxyz_pkg::COEF_RESET;
    end else if (cfg_i.valid) begin
      unique case (cxyz_pkg::cfg_reg_e'(cfg_i.index))
        cxyz_pkg::REG_X_BLUE:  coef_q[0] <= cfg_i.data;
        cxyz_pkg::REG_X_GREEN: coef_q[1] <= cfg_i.data;
        cxyz_pkg::REG_X_RED:   coef_q[2] <= cfg_i.data;
        cxyz_pkg::REG_Z_BLUE:  coef_q[3] <= cfg_i.data;
        cxyz_pkg::REG_Z_GREEN: coef_q[4] <= cfg_i.data;
        cxyz_pkg::REG_Z_RED:   coef_q[5] <= cfg_i.data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // a stage advances when empty or when the next stage advances
  assign en.en_out  = !v_out_q  || res_o.ready;
  assign en.en_sum  = !v_sum_q  || en.en_out;
  assign en.en_prod = !v_prod_q || en.en_sum;
  assign en_lum     = !v_lum_q  || en.en_prod;

  assign pix_i.ready = en_lum;
  assign accept      = pix_i.valid && en_lum;
  assign is_convert  = accept && (cxyz_pkg::op_e'(pix_i.operation) == cxyz_pkg::OP_CONVERT);
  assign is_load     = accept && (cxyz_pkg::op_e'(pix_i.operation) == cxyz_pkg::OP_LOAD);

  // table write decode; channel code three selects no table
  always_comb begin
    wr_en = '0;
    unique case (cxyz_pkg::chan_e'(pix_i.table_channel))
      cxyz_pkg::CH_BLUE:  wr_en[0] = is_load;
      cxyz_pkg::CH_GREEN: wr_en[1] = is_load;
      cxyz_pkg::CH_RED:   wr_en[2] = is_load;
      default: ;
    endcase
  end

  // every level of an 8-bit field lies inside the table, so no clamping
  cxyz_lut u_lut_blue (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en[0]),
    .wr_addr_i (pix_i.table_level),
    .wr_data_i (pix_i.table_value),
    .rd_en_i   (en_lum),
    .rd_addr_i (pix_i.blue),
    .rd_data_o (lum[0])
  );

  cxyz_lut u_lut_green (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en[1]),
    .wr_addr_i (pix_i.table_level),
    .wr_data_i (pix_i.table_value),
    .rd_en_i   (en_lum),
    .rd_addr_i (pix_i.green),
    .rd_data_o (lum[1])
  );

  cxyz_lut u_lut_red (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en[2]),
    .wr_addr_i (pix_i.table_level),
    .wr_data_i (pix_i.table_value),
    .rd_en_i   (en_lum),
    .rd_addr_i (pix_i.red),
    .rd_data_o (lum[2])
  );

  // valid bits follow the data through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_lum_q  <= 1'b0;
      v_prod_q <= 1'b0;
      v_sum_q  <= 1'b0;
      v_out_q  <= 1'b0;
    end else begin
      if (en_lum) begin
        v_lum_q <= is_convert;
      end
      if (en.en_prod) begin
        v_prod_q <= v_lum_q;
      end
      if (en.en_sum) begin
        v_sum_q <= v_prod_q;
      end
      if (en.en_out) begin
        v_out_q <= v_sum_q;
      end
    end
  end

  // y: three q16.4 luminances never exceed 22 bits, so no clipping
  assign y_prod_d = cxyz_pkg::Y_BITS'(lum[0]) + cxyz_pkg::Y_BITS'(lum[1])
                  + cxyz_pkg::Y_BITS'(lum[2]);

  always_ff @(posedge clk_i) begin
    if (en.en_prod) begin
      y_prod_q <= y_prod_d;
    end
    if (en.en_sum) begin
      y_sum_q <= y_prod_q;
    end
    if (en.en_out) begin
      y_out_q <= y_sum_q;
    end
  end

  assign coef_x = '{coef_q[0], coef_q[1], coef_q[2]};
  assign coef_z = '{coef_q[3], coef_q[4], coef_q[5]};

  cxyz_mac u_mac_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef_x),
    .lum_i   (lum),
    .value_o (res_o.x_out),
    .clip_o  (clip_x)
  );

  cxyz_mac u_mac_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef_z),
    .lum_i   (lum),
    .value_o (res_o.z_out),
    .clip_o  (clip_z)
  );

  assign res_o.valid     = v_out_q;
  assign res_o.y_out     = y_out_q;
  assign res_o.saturated = clip_x || clip_z;

endmodule

`default_nettype wire

@@ rtl/cxyz_assert.sv @@
// port-level assertions for the converter and their bind to the top level
`default_nettype none

module cxyz_assert (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                res_valid_i,
  input wire logic                                res_ready_i,
  input wire logic signed [cxyz_pkg::XZ_BITS-1:0] x_out_i,
  input wire logic [cxyz_pkg::Y_BITS-1:0]         y_out_i,
  input wire logic signed [cxyz_pkg::XZ_BITS-1:0] z_out_i,
  input wire logic                                saturated_i
);

  localparam logic signed [cxyz_pkg::XZ_BITS-1:0] XZ_MIN = {1'b1, {(cxyz_pkg::XZ_BITS-1){1'b0}}};
  localparam logic signed [cxyz_pkg::XZ_BITS-1:0] XZ_MAX = {1'b0, {(cxyz_pkg::XZ_BITS-1){1'b1}}};
  localparam logic [cxyz_pkg::Y_BITS-1:0] Y_LIMIT =
    cxyz_pkg::Y_BITS'(3 * ((1 << cxyz_pkg::LUMA_BITS) - 1));

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat withdrawn while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(x_out_i) && $stable(y_out_i) && $stable(z_out_i) && $stable(saturated_i))
    else $error("result payload changed while stalled");

  // clipping flag only with a value at a range limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && saturated_i |->
      x_out_i == XZ_MIN || x_out_i == XZ_MAX || z_out_i == XZ_MIN || z_out_i == XZ_MAX)
    else $error("saturated set without a clipped x or z");

  // y never exceeds the sum of three full-scale table entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> y_out_i <= Y_LIMIT)
    else $error("y beyond three full-scale luminances");

  // no result can appear in the cycle after reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !res_valid_i)
    else $error("result beat right after reset");

endmodule

bind camera_rgb_to_xyz_converter cxyz_assert u_cxyz_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .x_out_i     (res_o.x_out),
  .y_out_i     (res_o.y_out),
  .z_out_i     (res_o.z_out),
  .saturated_i (res_o.saturated)
);

`default_nettype wire
